FILE: src/ugs_pkg.sv
`default_nettype none
package ugs_pkg;

    localparam int unsigned MaxBytesDefault   = 4194304;
    localparam int unsigned MaxScalarsDefault = 1048576;

    localparam logic [20:0] ScalarMax = 21'h10ffff;
    localparam logic [20:0] SurrLo    = 21'h00d800;
    localparam logic [20:0] SurrHi    = 21'h00dfff;
    localparam logic [20:0] Zwj       = 21'h00200d;
    localparam logic [20:0] HangulLo  = 21'h00ac00;
    localparam logic [20:0] HangulHi  = 21'h00d7a3;
    localparam logic [20:0] CharCr    = 21'h00000d;
    localparam logic [20:0] CharLf    = 21'h00000a;

    typedef enum logic [1:0] {
        RES_CLUSTER  = 2'd0,
        RES_SUMMARY  = 2'd1,
        RES_REJECTED = 2'd2
    } res_kind_t;

    typedef enum logic [1:0] {
        DIR_NEUTRAL = 2'd0,
        DIR_LTR     = 2'd1,
        DIR_RTL     = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        HG_NONE = 3'd0,
        HG_L    = 3'd1,
        HG_V    = 3'd2,
        HG_T    = 3'd3,
        HG_LV   = 3'd4,
        HG_LVT  = 3'd5
    } hg_t;

    typedef struct packed {
        res_kind_t   kind;
        logic [21:0] offset;
        logic [22:0] nbytes;
        logic [20:0] nscalars;
        dir_t        dir;
        logic        eot;
    } result_t;

    function automatic logic is_control(input logic [20:0] x);
        return (x <= 21'h1f) || (x inside {[21'h7f:21'h9f]}) ||
               (x == 21'h2028) || (x == 21'h2029);
    endfunction

    function automatic logic is_extend(input logic [20:0] x);
        return x inside {[21'h300:21'h36f], [21'h483:21'h489], [21'h591:21'h5bd],
                         21'h5bf, [21'h5c1:21'h5c2], [21'h610:21'h61a],
                         [21'h64b:21'h65f], [21'h6d6:21'h6dc], [21'h6df:21'h6e4],
                         [21'h6e7:21'h6e8], [21'h6ea:21'h6ed], [21'h730:21'h74a],
                         [21'h7a6:21'h7b0], [21'h7eb:21'h7f3], [21'h816:21'h819],
                         [21'h81b:21'h823], [21'h825:21'h827], [21'h829:21'h82d],
                         [21'h900:21'h902], [21'h93a:21'h93c], [21'h93e:21'h94d],
                         [21'h1ab0:21'h1aff], [21'h1dc0:21'h1dff],
                         [21'h20d0:21'h20ff], [21'hfe00:21'hfe0f],
                         [21'hfe20:21'hfe2f], [21'h1f3fb:21'h1f3ff],
                         [21'he0100:21'he01ef]};
    endfunction

    function automatic logic is_spacing(input logic [20:0] x);
        return x inside {21'h903, 21'h93b, [21'h93e:21'h940], [21'h949:21'h94c],
                         [21'h982:21'h983]};
    endfunction

    function automatic logic is_prepend(input logic [20:0] x);
        return x inside {[21'h600:21'h605], 21'h6dd, 21'h70f, [21'h890:21'h891],
                         21'h8e2};
    endfunction

    function automatic logic is_ri(input logic [20:0] x);
        return x inside {[21'h1f1e6:21'h1f1ff]};
    endfunction

    function automatic logic is_pict(input logic [20:0] x);
        return x inside {[21'h1f000:21'h1faff], [21'h2600:21'h27bf]};
    endfunction

    function automatic logic is_rtl(input logic [20:0] x);
        return x inside {[21'h590:21'h8ff], [21'hfb1d:21'hfdff], [21'hfe70:21'hfefc],
                         [21'h10800:21'h10fff]};
    endfunction

    function automatic logic is_ltr(input logic [20:0] x);
        return x inside {[21'h41:21'h5a], [21'h61:21'h7a], [21'hc0:21'h2af],
                         [21'h370:21'h52f], [21'h900:21'h1fff]};
    endfunction

    // remainder by 28 through a reciprocal; exact for the syllable block
    function automatic hg_t hangul_class(input logic [20:0] x);
        logic [13:0] d;
        logic [27:0] prod;
        logic [13:0] q;
        logic [13:0] r;
        d    = 14'(x - HangulLo);
        prod = 28'(d) * 28'd9363;
        q    = 14'(prod >> 18);
        r    = d - 14'(q * 14'd28);
        if (x inside {[21'h1100:21'h115f], [21'ha960:21'ha97c]}) return HG_L;
        if (x inside {[21'h1160:21'h11a7], [21'hd7b0:21'hd7c6]}) return HG_V;
        if (x inside {[21'h11a8:21'h11ff], [21'hd7cb:21'hd7fb]}) return HG_T;
        if (!(x inside {[HangulLo:HangulHi]})) return HG_NONE;
        return (r == 14'd0) ? HG_LV : HG_LVT;
    endfunction

endpackage
`default_nettype wire

FILE: src/utf8_grapheme_segmenter.sv
`default_nettype none
// channel | direction | tdata                                  | tuser       | tlast
// s_      | in        | [7:0] byte_value                       | [0] kind    | -
// m_      | out       | [21:0] cluster_offset, [44:22] cluster_bytes,
//         |           | [65:45] cluster_scalars, [67:66] direction | [1:0] result_kind
//         |           |                                        |             | end_of_text
// One byte per cycle: decode and boundary rules sit between the state registers and a
// four-entry result queue. An end item yields up to two results; the queue drains one
// per cycle while m_tready is high; s_tready drops while fewer than two entries are free.
// aresetn is synchronous; it clears all text state and empties the queue.
module utf8_grapheme_segmenter #(
    parameter int unsigned MAX_BYTES   = ugs_pkg::MaxBytesDefault,
    parameter int unsigned MAX_SCALARS = ugs_pkg::MaxScalarsDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic [0:0]  s_tuser,   // [0] kind
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [71:0] m_tdata,   // offset, bytes, scalars, direction, zero fill
    output      logic [1:0]  m_tuser,   // [1:0] result_kind
    output      logic        m_tlast
);
    import ugs_pkg::*;

    localparam logic [22:0] MaxBytesW   = 23'(MAX_BYTES);
    localparam logic [22:0] MaxScalarsW = 23'(MAX_SCALARS);

    logic [1:0]  pending_reg, pending_next;
    logic [1:0]  seqlen_reg, seqlen_next;
    logic [20:0] partial_reg, partial_next;
    logic [22:0] sstart_reg, sstart_next;
    logic [22:0] bcount_reg, bcount_next;
    logic [22:0] stotal_reg, stotal_next;
    logic        havep_reg, havep_next;
    logic        pcr_reg, pcr_next;
    logic        pctrl_reg, pctrl_next;
    hg_t         phg_reg, phg_next;
    logic        pprep_reg, pprep_next;
    logic        pri_reg, pri_next;
    logic        pzwj_reg, pzwj_next;
    logic [22:0] ostart_reg, ostart_next;
    logic [20:0] ocount_reg, ocount_next;
    logic        riodd_reg, riodd_next;
    logic        pict_reg, pict_next;
    logic        jap_reg, jap_next;
    dir_t        dir_reg, dir_next;
    logic        failed_reg, failed_next;

    result_t     res0, res1;
    logic [1:0]  nres;

    result_t     q_mem [4];
    logic [1:0]  wr_reg, rd_reg;
    logic [2:0]  cnt_reg;

    logic        accept, pop;
    logic        complete;
    logic [20:0] x;
    logic [20:0] xmin;
    logic [22:0] scur;
    logic        x_ok, join_x;
    hg_t         hx;

    assign s_tready = (cnt_reg <= 3'd2);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (cnt_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        result_t r;
        r = '0;
        pending_next = pending_reg;
        seqlen_next  = seqlen_reg;
        partial_next = partial_reg;
        sstart_next  = sstart_reg;
        bcount_next  = bcount_reg;
        stotal_next  = stotal_reg;
        havep_next   = havep_reg;
        pcr_next     = pcr_reg;
        pctrl_next   = pctrl_reg;
        phg_next     = phg_reg;
        pprep_next   = pprep_reg;
        pri_next     = pri_reg;
        pzwj_next    = pzwj_reg;
        ostart_next  = ostart_reg;
        ocount_next  = ocount_reg;
        riodd_next   = riodd_reg;
        pict_next    = pict_reg;
        jap_next     = jap_reg;
        dir_next     = dir_reg;
        failed_next  = failed_reg;
        res0 = '0;
        res1 = '0;
        nres = 2'd0;
        complete = 1'b0;
        x = {13'd0, s_tdata};
        scur = (pending_reg == 2'd0) ? bcount_reg : sstart_reg;
        xmin = '0;

        if (pending_reg != 2'd0) begin
            x = {partial_reg[14:0], s_tdata[5:0]};
            case (seqlen_reg)
                2'd1:    xmin = 21'h80;
                2'd2:    xmin = 21'h800;
                2'd3:    xmin = 21'h10000;
                default: xmin = 21'h0;
            endcase
        end
        hx = hangul_class(x);
        x_ok = (x >= xmin) && (x <= ScalarMax) && !(x inside {[SurrLo:SurrHi]}) &&
               (stotal_reg < MaxScalarsW);
        join_x = 1'b0;
        if (pcr_reg && x == CharLf) join_x = 1'b1;
        else if (pctrl_reg || is_control(x)) join_x = 1'b0;
        else if (phg_reg == HG_L &&
                 (hx == HG_L || hx == HG_V || hx == HG_LV || hx == HG_LVT)) join_x = 1'b1;
        else if ((phg_reg == HG_LV || phg_reg == HG_V) && (hx == HG_V || hx == HG_T))
            join_x = 1'b1;
        else if ((phg_reg == HG_LVT || phg_reg == HG_T) && hx == HG_T) join_x = 1'b1;
        else if (is_extend(x) || x == Zwj || is_spacing(x) || pprep_reg) join_x = 1'b1;
        else if (pri_reg && is_ri(x)) join_x = riodd_reg;
        else if (is_pict(x) && pzwj_reg) join_x = jap_reg;

        if (accept) begin
            if (s_tuser[0]) begin
                if (failed_reg || pending_reg != 2'd0) begin
                    r.kind = RES_REJECTED;
                    r.eot  = 1'b1;
                    res0 = r;
                    nres = 2'd1;
                end else begin
                    r.kind = RES_SUMMARY;
                    r.dir  = dir_reg;
                    r.eot  = 1'b1;
                    if (havep_reg) begin
                        res0.kind     = RES_CLUSTER;
                        res0.offset   = ostart_reg[21:0];
                        res0.nbytes   = bcount_reg - ostart_reg;
                        res0.nscalars = ocount_reg;
                        res1 = r;
                        nres = 2'd2;
                    end else begin
                        res0 = r;
                        nres = 2'd1;
                    end
                end
                pending_next = '0; seqlen_next = '0; partial_next = '0;
                sstart_next = '0; bcount_next = '0; stotal_next = '0;
                havep_next = 1'b0; pcr_next = 1'b0; pctrl_next = 1'b0;
                phg_next = HG_NONE; pprep_next = 1'b0; pri_next = 1'b0;
                pzwj_next = 1'b0; ostart_next = '0; ocount_next = '0;
                riodd_next = 1'b0; pict_next = 1'b0; jap_next = 1'b0;
                dir_next = DIR_NEUTRAL; failed_next = 1'b0;
            end else if (!failed_reg) begin
                if (bcount_reg >= MaxBytesW) begin
                    failed_next = 1'b1;
                end else begin
                    bcount_next = bcount_reg + 23'd1;
                    if (pending_reg == 2'd0) begin
                        sstart_next = bcount_reg;
                        if (s_tdata <= 8'h7f) begin
                            seqlen_next = 2'd0;
                            complete = 1'b1;
                        end else if (s_tdata inside {[8'hc2:8'hdf]}) begin
                            seqlen_next = 2'd1; pending_next = 2'd1;
                            partial_next = {16'd0, s_tdata[4:0]};
                        end else if (s_tdata inside {[8'he0:8'hef]}) begin
                            seqlen_next = 2'd2; pending_next = 2'd2;
                            partial_next = {17'd0, s_tdata[3:0]};
                        end else if (s_tdata inside {[8'hf0:8'hf4]}) begin
                            seqlen_next = 2'd3; pending_next = 2'd3;
                            partial_next = {18'd0, s_tdata[2:0]};
                        end else begin
                            failed_next = 1'b1;
                        end
                    end else if (s_tdata[7:6] != 2'b10) begin
                        failed_next = 1'b1;
                    end else begin
                        partial_next = x;
                        pending_next = pending_reg - 2'd1;
                        complete = (pending_reg == 2'd1);
                    end
                end
                if (complete) begin
                    if (!x_ok) begin
                        failed_next = 1'b1;
                    end else begin
                        if (havep_reg && join_x) begin
                            ocount_next = ocount_reg + 21'd1;
                        end else begin
                            if (havep_reg) begin
                                res0.kind     = RES_CLUSTER;
                                res0.offset   = ostart_reg[21:0];
                                res0.nbytes   = scur - ostart_reg;
                                res0.nscalars = ocount_reg;
                                nres = 2'd1;
                            end
                            ostart_next = scur;
                            ocount_next = 21'd1;
                        end
                        jap_next = (x == Zwj) && pict_reg;
                        if (!is_extend(x)) pict_next = is_pict(x);
                        riodd_next = is_ri(x) ? !riodd_reg : 1'b0;
                        if (dir_reg == DIR_NEUTRAL) begin
                            if (is_rtl(x)) dir_next = DIR_RTL;
                            else if (is_ltr(x)) dir_next = DIR_LTR;
                        end
                        havep_next  = 1'b1;
                        pcr_next    = (x == CharCr);
                        pctrl_next  = is_control(x);
                        phg_next    = hx;
                        pprep_next  = is_prepend(x);
                        pri_next    = is_ri(x);
                        pzwj_next   = (x == Zwj);
                        stotal_next = stotal_reg + 23'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0; seqlen_reg <= '0; partial_reg <= '0;
            sstart_reg <= '0; bcount_reg <= '0; stotal_reg <= '0;
            havep_reg <= 1'b0; pcr_reg <= 1'b0; pctrl_reg <= 1'b0;
            phg_reg <= HG_NONE; pprep_reg <= 1'b0; pri_reg <= 1'b0;
            pzwj_reg <= 1'b0; ostart_reg <= '0; ocount_reg <= '0;
            riodd_reg <= 1'b0; pict_reg <= 1'b0; jap_reg <= 1'b0;
            dir_reg <= DIR_NEUTRAL; failed_reg <= 1'b0;
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end else begin
            pending_reg <= pending_next; seqlen_reg <= seqlen_next;
            partial_reg <= partial_next; sstart_reg <= sstart_next;
            bcount_reg <= bcount_next; stotal_reg <= stotal_next;
            havep_reg <= havep_next; pcr_reg <= pcr_next; pctrl_reg <= pctrl_next;
            phg_reg <= phg_next; pprep_reg <= pprep_next; pri_reg <= pri_next;
            pzwj_reg <= pzwj_next; ostart_reg <= ostart_next; ocount_reg <= ocount_next;
            riodd_reg <= riodd_next; pict_reg <= pict_next; jap_reg <= jap_next;
            dir_reg <= dir_next; failed_reg <= failed_next;
            wr_reg  <= wr_reg + nres;
            rd_reg  <= rd_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, nres} - {2'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (nres != 2'd0) q_mem[wr_reg] <= res0;
        if (nres == 2'd2) q_mem[wr_reg + 2'd1] <= res1;
    end

    always_comb begin
        result_t h;
        h = q_mem[rd_reg];
        m_tdata = {4'd0, h.dir, h.nscalars, h.nbytes, h.offset};
        m_tuser = h.kind;
        m_tlast = h.eot;
    end

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
module tb;
    import ugs_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    utf8_grapheme_segmenter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    localparam logic TEXT_BYTE = 1'b0;
    localparam logic TEXT_END  = 1'b1;
    localparam int   WATCHDOG  = 20000;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } text_item_t;

    text_item_t pending_items[$];
    result_t    expected_results[$];

    // segmenter state copy
    logic [1:0]  st_pending;
    logic [1:0]  st_seqlen;
    logic [20:0] st_partial;
    logic [22:0] st_scalar_start;
    logic [22:0] st_byte_count;
    logic [20:0] st_scalar_total;
    logic [20:0] st_prev;
    logic        st_have_prev;
    logic [22:0] st_open_start;
    logic [20:0] st_open_count;
    logic        st_ri_odd;
    logic        st_pict_run;
    logic        st_zwj_pict;
    dir_t        st_dir;
    logic        st_failed;

    int mismatches;
    int idle_cycles;
    bit stimulus_done;

    function automatic bit in_span(logic [20:0] x, int lo, int hi);
        return x >= lo && x <= hi;
    endfunction

    function automatic bit ctl_cp(logic [20:0] x);
        return x <= 'h1f || in_span(x, 'h7f, 'h9f) || x == 'h2028 || x == 'h2029;
    endfunction

    function automatic bit ext_cp(logic [20:0] x);
        int spans[28][2] = '{
            '{'h300,'h36f}, '{'h483,'h489}, '{'h591,'h5bd}, '{'h5bf,'h5bf},
            '{'h5c1,'h5c2}, '{'h610,'h61a}, '{'h64b,'h65f}, '{'h6d6,'h6dc},
            '{'h6df,'h6e4}, '{'h6e7,'h6e8}, '{'h6ea,'h6ed}, '{'h730,'h74a},
            '{'h7a6,'h7b0}, '{'h7eb,'h7f3}, '{'h816,'h819}, '{'h81b,'h823},
            '{'h825,'h827}, '{'h829,'h82d}, '{'h900,'h902}, '{'h93a,'h93c},
            '{'h93e,'h94d}, '{'h1ab0,'h1aff}, '{'h1dc0,'h1dff}, '{'h20d0,'h20ff},
            '{'hfe00,'hfe0f}, '{'hfe20,'hfe2f}, '{'h1f3fb,'h1f3ff}, '{'he0100,'he01ef}};
        foreach (spans[k])
            if (in_span(x, spans[k][0], spans[k][1])) return 1;
        return 0;
    endfunction

    function automatic bit ri_cp(logic [20:0] x);
        return in_span(x, 'h1f1e6, 'h1f1ff);
    endfunction

    function automatic bit pict_cp(logic [20:0] x);
        return in_span(x, 'h1f000, 'h1faff) || in_span(x, 'h2600, 'h27bf);
    endfunction

    function automatic hg_t jamo_class(logic [20:0] x);
        if (in_span(x, 'h1100, 'h115f) || in_span(x, 'ha960, 'ha97c)) return HG_L;
        if (in_span(x, 'h1160, 'h11a7) || in_span(x, 'hd7b0, 'hd7c6)) return HG_V;
        if (in_span(x, 'h11a8, 'h11ff) || in_span(x, 'hd7cb, 'hd7fb)) return HG_T;
        if (!in_span(x, 'hac00, 'hd7a3)) return HG_NONE;
        return ((int'(x) - 'hac00) % 28 == 0) ? HG_LV : HG_LVT;
    endfunction

    function automatic bit no_boundary(logic [20:0] a, logic [20:0] b);
        hg_t ha;
        hg_t hb;
        bit  spacing;
        bit  prep;
        ha = jamo_class(a);
        hb = jamo_class(b);
        spacing = b == 'h903 || b == 'h93b || in_span(b, 'h93e, 'h940) ||
                  in_span(b, 'h949, 'h94c) || in_span(b, 'h982, 'h983);
        prep = in_span(a, 'h600, 'h605) || a == 'h6dd || a == 'h70f ||
               in_span(a, 'h890, 'h891) || a == 'h8e2;
        if (a == 'h0d && b == 'h0a) return 1;
        if (ctl_cp(a) || ctl_cp(b)) return 0;
        if (ha == HG_L && hb inside {HG_L, HG_V, HG_LV, HG_LVT}) return 1;
        if (ha inside {HG_LV, HG_V} && hb inside {HG_V, HG_T}) return 1;
        if (ha inside {HG_LVT, HG_T} && hb == HG_T) return 1;
        if (ext_cp(b) || b == 'h200d || spacing || prep) return 1;
        if (ri_cp(a) && ri_cp(b)) return st_ri_odd;
        if (pict_cp(b) && a == 'h200d) return st_zwj_pict;
        return 0;
    endfunction

    function automatic result_t make_result(res_kind_t k, logic [22:0] off, logic [22:0] len,
                                            logic [20:0] cnt, dir_t d, logic eot);
        result_t r;
        r.kind = k; r.offset = off[21:0]; r.nbytes = len; r.nscalars = cnt;
        r.dir = d; r.eot = eot;
        return r;
    endfunction

    task automatic expect_result(result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic clear_text();
        st_pending = 0; st_seqlen = 0; st_partial = 0; st_scalar_start = 0;
        st_byte_count = 0; st_scalar_total = 0; st_prev = 0; st_have_prev = 0;
        st_open_start = 0; st_open_count = 0; st_ri_odd = 0; st_pict_run = 0;
        st_zwj_pict = 0; st_dir = DIR_NEUTRAL; st_failed = 0;
    endtask

    task automatic close_scalar(logic [20:0] x);
        logic [20:0] floor_v;
        floor_v = st_seqlen == 0 ? 21'h0 : st_seqlen == 1 ? 21'h80 :
                  st_seqlen == 2 ? 21'h800 : 21'h10000;
        if (x < floor_v || x > 'h10ffff || in_span(x, 'hd800, 'hdfff) ||
            st_scalar_total >= MaxScalarsDefault) begin
            st_failed = 1;
            return;
        end
        if (st_have_prev && no_boundary(st_prev, x)) begin
            st_open_count++;
        end else begin
            if (st_have_prev)
                expect_result(make_result(RES_CLUSTER, st_open_start,
                    st_scalar_start - st_open_start, st_open_count, DIR_NEUTRAL, 0));
            st_open_start = st_scalar_start;
            st_open_count = 1;
        end
        st_zwj_pict = (x == 'h200d) && st_pict_run;
        if (!ext_cp(x)) st_pict_run = pict_cp(x);
        st_ri_odd = ri_cp(x) ? !st_ri_odd : 1'b0;
        if (st_dir == DIR_NEUTRAL) begin
            if (in_span(x, 'h590, 'h8ff) || in_span(x, 'hfb1d, 'hfdff) ||
                in_span(x, 'hfe70, 'hfefc) || in_span(x, 'h10800, 'h10fff))
                st_dir = DIR_RTL;
            else if (in_span(x, 'h41, 'h5a) || in_span(x, 'h61, 'h7a) ||
                     in_span(x, 'hc0, 'h2af) || in_span(x, 'h370, 'h52f) ||
                     in_span(x, 'h900, 'h1fff))
                st_dir = DIR_LTR;
        end
        st_prev = x;
        st_have_prev = 1;
        st_scalar_total++;
    endtask

    task automatic predict_segments(text_item_t it);
        logic [7:0] b;
        b = it.value;
        if (it.kind == TEXT_END) begin
            if (st_failed || st_pending != 0) begin
                expect_result(make_result(RES_REJECTED, 0, 0, 0, DIR_NEUTRAL, 1));
            end else begin
                if (st_have_prev)
                    expect_result(make_result(RES_CLUSTER, st_open_start,
                        st_byte_count - st_open_start, st_open_count, DIR_NEUTRAL, 0));
                expect_result(make_result(RES_SUMMARY, 0, 0, 0, st_dir, 1));
            end
            clear_text();
            return;
        end
        if (st_failed) return;
        if (st_byte_count >= MaxBytesDefault) begin
            st_failed = 1;
            return;
        end
        st_byte_count++;
        if (st_pending == 0) begin
            st_scalar_start = st_byte_count - 23'd1;
            if (b <= 8'h7f) begin
                st_seqlen = 0;
                close_scalar({13'h0, b});
                return;
            end
            if (b inside {[8'hc2:8'hdf]}) begin
                st_seqlen = 1; st_partial = {16'd0, b[4:0]};
            end else if (b inside {[8'he0:8'hef]}) begin
                st_seqlen = 2; st_partial = {17'd0, b[3:0]};
            end else if (b inside {[8'hf0:8'hf4]}) begin
                st_seqlen = 3; st_partial = {18'd0, b[2:0]};
            end else begin
                st_failed = 1;
                return;
            end
            st_pending = st_seqlen;
            return;
        end
        if (b[7:6] != 2'b10) begin
            st_failed = 1;
            return;
        end
        st_partial = {st_partial[14:0], b[5:0]};
        st_pending--;
        if (st_pending == 0) close_scalar(st_partial);
    endtask

    task automatic queue_item(logic kind, logic [7:0] value);
        text_item_t it;
        it.kind  = kind;
        it.value = value;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_byte(logic [7:0] b);
        queue_item(TEXT_BYTE, b);
    endtask

    task automatic push_end();
        queue_item(TEXT_END, 8'($urandom));
    endtask

    task automatic push_scalar(logic [20:0] x);
        if (x < 'h80) begin
            push_byte(x[7:0]);
        end else if (x < 'h800) begin
            push_byte({3'b110, x[10:6]}); push_byte({2'b10, x[5:0]});
        end else if (x < 'h10000) begin
            push_byte({4'b1110, x[15:12]}); push_byte({2'b10, x[11:6]});
            push_byte({2'b10, x[5:0]});
        end else begin
            push_byte({5'b11110, x[20:18]}); push_byte({2'b10, x[17:12]});
            push_byte({2'b10, x[11:6]}); push_byte({2'b10, x[5:0]});
        end
    endtask

    function automatic logic [20:0] pick_scalar();
        int unsigned pool[24] = '{'h0d, 'h0a, 'h41, 'h7a, 'h20, 'h301, 'h5d0, 'h627, 'h600,
            'h903, 'h93f, 'h1100, 'h1161, 'h11a8, 'hac00, 'hac01, 'h200d, 'h1f1e6, 'h1f1ff,
            'h1f600, 'h2764, 'h1f3fb, 'h10900, 'h2028};
        case ($urandom_range(0, 3))
            0: return 21'($urandom_range(0, 'h7f));
            1: return 21'($urandom_range('h80, 'hd7ff));
            2: return 21'($urandom_range('he000, 'h10ffff));
            default: return 21'(pool[$urandom_range(0, 23)]);
        endcase
    endfunction

    initial begin
        int n;
        // directed
        push_end();
        push_byte(8'h00); push_byte(8'h7f); push_byte(8'h0d); push_byte(8'h0a); push_end();
        push_scalar('h1f1e6); push_scalar('h1f1e7); push_scalar('h1f1e8); push_end();
        push_scalar('h1f600); push_scalar('h200d); push_scalar('h2764); push_end();
        push_scalar('h10ffff); push_scalar('h1100); push_scalar('hac00); push_end();
        push_byte(8'hc0); push_byte(8'hff); push_end();
        push_byte(8'he0); push_byte(8'h80); push_byte(8'h80); push_end();
        push_byte(8'hed); push_byte(8'ha0); push_byte(8'h80); push_end();
        push_byte(8'hf4); push_byte(8'h90); push_byte(8'h80); push_byte(8'h80); push_end();
        push_byte(8'hf0); push_byte(8'h9f); push_end();
        push_byte(8'h41); push_byte(8'h41); push_end();
        // random
        n = 0;
        while (n < 500) begin
            int len;
            len = $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0) len = $urandom_range(20, 40);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_byte(8'($urandom)); n++;
                end else begin
                    int before_sz;
                    before_sz = pending_items.size();
                    push_scalar(pick_scalar());
                    n += pending_items.size() - before_sz;
                end
            end
            if ($urandom_range(0, 15) == 0) begin
                push_byte(8'($urandom_range('hc2, 'hf4))); n++;
            end
            push_end(); n++;
        end
    end

    initial aclk = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    initial begin
        aresetn = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
    end

    int send_gap;
    int recv_gap;
    int hold_count;
    bit hold_done;
    int sent_count;

    function automatic int random_gap();
        if ($urandom_range(0, 2) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    initial begin
        clear_text();
        s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
        mismatches = 0; idle_cycles = 0; stimulus_done = 0;
        send_gap = 0; recv_gap = 0; hold_count = 0; hold_done = 0;
        sent_count = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                text_item_t acc;
                acc.kind  = s_tuser[0];
                acc.value = s_tdata;
                predict_segments(acc);
                sent_count++;
            end
            if (s_tvalid && !s_tready) begin
                // hold
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 0;
            end else if (pending_items.size() > 0) begin
                text_item_t it;
                it = pending_items.pop_front();
                s_tvalid <= 1;
                s_tuser  <= it.kind;
                s_tdata  <= it.value;
                if (sent_count > 100) send_gap = random_gap();
            end else begin
                s_tvalid <= 0;
                if (!(s_tvalid && !s_tready)) stimulus_done = 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_t got;
                got = '{res_kind_t'(m_tuser), m_tdata[21:0], m_tdata[44:22], m_tdata[65:45],
                        dir_t'(m_tdata[67:66]), m_tlast};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    result_t want;
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (!hold_done && sent_count > 30) begin
                hold_count++;
                if (hold_count >= 60) hold_done = 1;
                m_tready <= 0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                if (sent_count > 100) recv_gap = random_gap();
            end
        end
    end

    initial begin
        @(posedge aresetn);
        while (!(stimulus_done && expected_results.size() == 0)) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("TB_ERROR");
                $finish;
            end
        end
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0 && !m_tvalid) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
